/* src/histogram_largest_rectangle_unit_defines.svh */
// ----------------------------------------------------------------------------
// histogram_largest_rectangle_unit_defines.svh
// Assertion macros for the histogram largest rectangle unit.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_LARGEST_RECTANGLE_UNIT_DEFINES_SVH
`define HISTOGRAM_LARGEST_RECTANGLE_UNIT_DEFINES_SVH

// same-cycle implication
`define HLR_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hlr: same-cycle check failed");

// next-cycle implication
`define HLR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hlr: next-cycle check failed");

`endif

/* src/hlr_pkg.sv */
// ----------------------------------------------------------------------------
// hlr_pkg
// Shared types and constants of the histogram largest rectangle unit.
// ----------------------------------------------------------------------------
package hlr_pkg;

   localparam int HEIGHT_W = 16;
   localparam int AREA_W   = 26;
   localparam int WIDTH_W  = 11;

   localparam logic [AREA_W-1:0] AREA_LIMIT = 26'h3FF_FFFF;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_WAIT  = 6'b000100,
      ST_POP   = 6'b001000,
      ST_UPD   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

/* src/hlr_ram.sv */
// ----------------------------------------------------------------------------
// hlr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hlr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/hlr_area.sv */
// ----------------------------------------------------------------------------
// hlr_area
// Registered height times width product, saturated to the area field.
// ----------------------------------------------------------------------------
module hlr_area #(
   parameter int HB = 16,
   parameter int WB = 11
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [HB-1:0]               height,
   input  logic [WB-1:0]               width,
   output logic [hlr_pkg::AREA_W-1:0]  area
);

   localparam int PW = HB + WB;
   localparam int EW = (PW > hlr_pkg::AREA_W) ? PW : hlr_pkg::AREA_W;

   logic [PW-1:0] prod_ff;
   logic [PW-1:0] prod_in;
   logic [EW-1:0] prod_ext;

   assign prod_in  = PW'(height) * PW'(width);
   assign prod_ext = EW'(prod_ff);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign area = (prod_ext > EW'(hlr_pkg::AREA_LIMIT)) ? hlr_pkg::AREA_LIMIT
                                                       : hlr_pkg::AREA_W'(prod_ext);

endmodule

/* src/histogram_largest_rectangle_unit.sv */
// Push of a bar: IDLE accepts it, CHECK pops taller bars, then pushes it and returns to IDLE.
// Each pop: CHECK (compare, stack memory read), WAIT, POP (multiply), UPD (best update).
// Last bar: its pops, its push, then a flush that pops every held bar, and DONE
// loads the result register; on overflow the last bar is not pushed.
// Synchronous reset clears control and sequence state; the stack
// memory is not cleared, only entries below the stack depth are used.
// ----------------------------------------------------------------------------
// histogram_largest_rectangle_unit
// Largest rectangle in a histogram using a monotonic stack held in RAM.
// The top entry is cached in registers, entries below it live in memory.
// ----------------------------------------------------------------------------
`include "histogram_largest_rectangle_unit_defines.svh"

module histogram_largest_rectangle_unit #(
   parameter int MAX_BARS    = 1024,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hlr_pkg::HEIGHT_W-1:0]  req_bar_height,
   input  logic                          req_last_bar,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hlr_pkg::AREA_W-1:0]    rsp_max_area,
   output logic [hlr_pkg::HEIGHT_W-1:0]  rsp_best_height,
   output logic [hlr_pkg::WIDTH_W-1:0]   rsp_best_width,
   output logic                          rsp_overflow
);

   localparam int HB = HEIGHT_BITS;
   localparam int PB = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
   localparam int WB = $clog2(MAX_BARS + 1);
   localparam int EB = HB + PB;

   hlr_pkg::state_type state_ff, state_in;

   logic [WB-1:0]              depth_ff, depth_in;
   logic [WB-1:0]              count_ff, count_in;
   logic [hlr_pkg::AREA_W-1:0] best_area_ff, best_area_in;
   logic [HB-1:0]              best_h_ff, best_h_in;
   logic [WB-1:0]              best_w_ff, best_w_in;
   logic                       ovf_ff, ovf_in;
   logic                       flush_ff, flush_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [HB-1:0]              h_ff, h_in;
   logic                       last_ff, last_in;
   logic [HB-1:0]              top_h_ff, top_h_in;
   logic [PB-1:0]              top_p_ff, top_p_in;
   logic [WB-1:0]              w_ff, w_in;
   logic [hlr_pkg::AREA_W-1:0] rsp_area_ff, rsp_area_in;
   logic [HB-1:0]              rsp_h_ff, rsp_h_in;
   logic [WB-1:0]              rsp_w_ff, rsp_w_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   logic                       ram_we;
   logic [PB-1:0]              ram_waddr;
   logic [EB-1:0]              ram_wdata;
   logic                       ram_re;
   logic [PB-1:0]              ram_raddr;
   logic [EB-1:0]              ram_rdata;
   logic [HB-1:0]              below_h;
   logic [PB-1:0]              below_p;

   logic                       area_load;
   logic [hlr_pkg::AREA_W-1:0] area;
   logic                       pop_ok;

   assign below_h = ram_rdata[EB-1:PB];
   assign below_p = ram_rdata[PB-1:0];
   assign pop_ok  = (depth_ff != '0) && (flush_ff || (top_h_ff > h_ff));

   hlr_ram #(
      .WIDTH (EB),
      .DEPTH (MAX_BARS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   hlr_area #(
      .HB (HB),
      .WB (WB)
   ) u_area (
      .clock  (clock),
      .load   (area_load),
      .height (top_h_ff),
      .width  (w_in),
      .area   (area)
   );

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      best_area_in = best_area_ff;
      best_h_in    = best_h_ff;
      best_w_in    = best_w_ff;
      ovf_in       = ovf_ff;
      flush_in     = flush_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      h_in         = h_ff;
      last_in      = last_ff;
      top_h_in     = top_h_ff;
      top_p_in     = top_p_ff;
      w_in         = w_ff;
      rsp_area_in  = rsp_area_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_we       = 1'b0;
      ram_waddr    = PB'(depth_ff - WB'(1));
      ram_wdata    = {top_h_ff, top_p_ff};
      ram_re       = 1'b0;
      ram_raddr    = PB'(depth_ff - WB'(2));
      area_load    = 1'b0;

      case (state_ff)
         hlr_pkg::ST_IDLE: begin
            if (req_valid) begin
               h_in    = HB'(req_bar_height);
               last_in = req_last_bar;
               if (count_ff < WB'(MAX_BARS)) begin
                  flush_in = 1'b0;
                  state_in = hlr_pkg::ST_CHECK;
               end else begin
                  ovf_in = 1'b1;
                  if (req_last_bar) begin
                     flush_in = 1'b1;
                     state_in = hlr_pkg::ST_CHECK;
                  end
               end
            end
         end
         hlr_pkg::ST_CHECK: begin
            if (pop_ok) begin
               ram_re   = 1'b1;
               state_in = hlr_pkg::ST_WAIT;
            end else if (flush_ff) begin
               state_in = hlr_pkg::ST_DONE;
            end else begin
               ram_we   = (depth_ff != '0);
               top_h_in = h_ff;
               top_p_in = PB'(count_ff);
               depth_in = depth_ff + WB'(1);
               count_in = count_ff + WB'(1);
               if (last_ff) begin
                  flush_in = 1'b1;
               end else begin
                  state_in = hlr_pkg::ST_IDLE;
               end
            end
         end
         hlr_pkg::ST_WAIT: begin
            state_in = hlr_pkg::ST_POP;
         end
         hlr_pkg::ST_POP: begin
            if (depth_ff == WB'(1)) begin
               w_in = count_ff;
            end else begin
               w_in = count_ff - WB'(below_p) - WB'(1);
            end
            area_load = 1'b1;
            state_in  = hlr_pkg::ST_UPD;
         end
         hlr_pkg::ST_UPD: begin
            if (best_area_ff < area) begin
               best_area_in = area;
               best_h_in    = top_h_ff;
               best_w_in    = w_ff;
            end
            depth_in = depth_ff - WB'(1);
            top_h_in = below_h;
            top_p_in = below_p;
            state_in = hlr_pkg::ST_CHECK;
         end
         hlr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = best_area_ff;
               rsp_h_in     = best_h_ff;
               rsp_w_in     = best_w_ff;
               rsp_ovf_in   = ovf_ff;
               depth_in     = '0;
               count_in     = '0;
               best_area_in = '0;
               best_h_in    = '0;
               best_w_in    = '0;
               ovf_in       = 1'b0;
               flush_in     = 1'b0;
               state_in     = hlr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hlr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hlr_pkg::ST_IDLE;
         depth_ff     <= '0;
         count_ff     <= '0;
         best_area_ff <= '0;
         best_h_ff    <= '0;
         best_w_ff    <= '0;
         ovf_ff       <= 1'b0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         best_area_ff <= best_area_in;
         best_h_ff    <= best_h_in;
         best_w_ff    <= best_w_in;
         ovf_ff       <= ovf_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      last_ff     <= last_in;
      top_h_ff    <= top_h_in;
      top_p_ff    <= top_p_in;
      w_ff        <= w_in;
      rsp_area_ff <= rsp_area_in;
      rsp_h_ff    <= rsp_h_in;
      rsp_w_ff    <= rsp_w_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_stall       = (state_ff != hlr_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_area    = rsp_area_ff;
   assign rsp_best_height = hlr_pkg::HEIGHT_W'(rsp_h_ff);
   assign rsp_best_width  = hlr_pkg::WIDTH_W'(rsp_w_ff);
   assign rsp_overflow    = rsp_ovf_ff;

   `HLR_ASSERT_IMPL(a_depth_le_count, clock, reset, 1'b1, depth_ff <= count_ff)
   `HLR_ASSERT_IMPL(a_count_le_max, clock, reset, 1'b1, count_ff <= WB'(MAX_BARS))
   `HLR_ASSERT_NEXT(a_pop_then_upd, clock, reset, state_ff == hlr_pkg::ST_POP,
                    state_ff == hlr_pkg::ST_UPD)
   `HLR_ASSERT_NEXT(a_upd_pops, clock, reset, state_ff == hlr_pkg::ST_UPD,
                    depth_ff == $past(depth_ff) - WB'(1))
   `HLR_ASSERT_NEXT(a_empty_flush_done, clock, reset,
                    state_ff == hlr_pkg::ST_CHECK && flush_ff && depth_ff == '0,
                    state_ff == hlr_pkg::ST_DONE)

endmodule
